>>> hw/rtl/msf_time_code_modulator_assert.svh
// assertion macros used by the msf time-code modulator rtl
// depends on signals named clock and reset in the module that includes it
`ifndef MSF_TIME_CODE_MODULATOR_ASSERT_SVH
`define MSF_TIME_CODE_MODULATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MSF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/msf_tcm_pkg.sv
// types, constants and helpers of the msf time-code modulator
// no dependencies
`timescale 1ns / 1ps

package msf_tcm_pkg;

   // operation codes of an input beat
   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_MODULATE = 1'b1;

   localparam int unsigned FRAME_BITS = 60;

   // fixed minute marker in the low eight bits of the a frame
   localparam logic [7:0] MARKER_BITS = 8'h7E;

   // segment lengths in ms
   localparam logic [8:0] SYNC_MS = 9'd500;
   localparam logic [8:0] BIT_MS  = 9'd100;
   localparam logic [8:0] HOLD_MS = 9'd0;

   // last second of the minute, maps second to frame bit position
   localparam logic [5:0] SEC_LAST = 6'd59;

   // b frame bit of the summer-time flag
   localparam int unsigned SUMMER_POS = 59 - 58;

   // captured work for one modulation beat
   typedef struct packed {
      logic sync;
      logic a_bit;
      logic b_bit;
   } job_type;

   // handshake view of the sequencer towards the top level
   typedef struct packed {
      logic take_ready;
   } seq_status_type;

   // two bcd digits, tens digit modulo ten; input below 128
   function automatic logic [7:0] bcd2(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [3:0]  tens_mod;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'(v) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'(tens) * 7'd10;
      ones     = v - tens_x10;
      tens_mod = (tens >= 4'd10) ? tens - 4'd10 : tens;
      return {tens_mod, ones[3:0]};
   endfunction

endpackage

>>> hw/rtl/msf_tcm_frame_store.sv
// a and b frame registers: encoding on load and per-second bit lookup
// depends on msf_tcm_pkg
`timescale 1ns / 1ps

module msf_tcm_frame_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_en,
   input  logic [6:0]                   year_of_century,
   input  logic [3:0]                   month,
   input  logic [4:0]                   day_of_month,
   input  logic [2:0]                   weekday,
   input  logic [4:0]                   hour,
   input  logic [5:0]                   minute,
   input  logic                         summer_time,
   input  logic [5:0]                   second,
   output msf_tcm_pkg::job_type         job
);
   import msf_tcm_pkg::*;

   logic [FRAME_BITS-1:0] frame_a_ff, frame_a_in;
   logic [FRAME_BITS-1:0] frame_b_ff, frame_b_in;
   logic [7:0] year_bcd, month_bcd, day_bcd, wday_bcd, hour_bcd, min_bcd;
   logic [5:0] pos;
   logic       in_frame;

   // bcd digits of each time field
   always_comb begin
      year_bcd  = bcd2(year_of_century);
      month_bcd = bcd2(7'(month));
      day_bcd   = bcd2(7'(day_of_month));
      wday_bcd  = bcd2(7'(weekday));
      hour_bcd  = bcd2(7'(hour));
      min_bcd   = bcd2(7'(minute));
   end

   // a frame layout and odd-parity b frame
   always_comb begin
      frame_a_in        = '0;
      frame_a_in[7:0]   = MARKER_BITS;
      frame_a_in[14:8]  = min_bcd[6:0];
      frame_a_in[20:15] = hour_bcd[5:0];
      frame_a_in[23:21] = wday_bcd[2:0];
      frame_a_in[29:24] = day_bcd[5:0];
      frame_a_in[34:30] = month_bcd[4:0];
      frame_a_in[42:35] = year_bcd;

      frame_b_in             = '0;
      frame_b_in[5]          = ~^frame_a_in[42:35];
      frame_b_in[4]          = ~^frame_a_in[34:24];
      frame_b_in[3]          = ~^frame_a_in[23:21];
      frame_b_in[2]          = ~^frame_a_in[20:8];
      frame_b_in[SUMMER_POS] = summer_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_a_ff <= '0;
         frame_b_ff <= '0;
      end else if (load_en) begin
         frame_a_ff <= frame_a_in;
         frame_b_ff <= frame_b_in;
      end
   end

   // bits of the requested second from the frames as they stand now
   always_comb begin
      pos       = SEC_LAST - second;
      in_frame  = (second != 6'd0) && (second <= SEC_LAST);
      job.sync  = (second == 6'd0);
      job.a_bit = in_frame & frame_a_ff[pos];
      job.b_bit = in_frame & frame_b_ff[pos];
   end

endmodule

>>> hw/rtl/msf_tcm_seg_sequencer.sv
// job register and result register: steps one second through its segments
// depends on msf_tcm_pkg and msf_time_code_modulator_assert.svh
`timescale 1ns / 1ps

module msf_tcm_seg_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_take,
   input  msf_tcm_pkg::job_type         job_new,
   output msf_tcm_pkg::seq_status_type  status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_carrier_high,
   output logic [8:0]                   rsp_duration_ms,
   output logic                         rsp_last_segment
);
   import msf_tcm_pkg::*;
   `include "msf_time_code_modulator_assert.svh"

   // segment codes
   localparam logic [1:0] SEG_LEAD = 2'd0;
   localparam logic [1:0] SEG_A    = 2'd1;
   localparam logic [1:0] SEG_B    = 2'd2;
   localparam logic [1:0] SEG_TAIL = 2'd3;

   logic       job_valid_ff, job_valid_in;
   job_type    job_ff, job_in;
   logic [1:0] seg_ff, seg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       carrier_ff, carrier_in;
   logic [8:0] dur_ff, dur_in;
   logic       last_ff, last_in;
   logic       job_advance;
   logic       job_last;

   assign job_advance       = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign job_last          = (seg_ff == SEG_TAIL);
   assign status.take_ready = !job_valid_ff || (job_advance && job_last);

   // segment contents of the current step
   always_comb begin
      carrier_in = 1'b1;
      dur_in     = HOLD_MS;
      last_in    = 1'b0;
      unique case (seg_ff)
         SEG_LEAD: begin
            carrier_in = 1'b0;
            dur_in     = job_ff.sync ? SYNC_MS : BIT_MS;
         end
         SEG_A: begin
            carrier_in = !job_ff.a_bit;
            dur_in     = BIT_MS;
         end
         SEG_B: begin
            carrier_in = !job_ff.b_bit;
            dur_in     = BIT_MS;
         end
         SEG_TAIL: begin
            carrier_in = 1'b1;
            dur_in     = HOLD_MS;
            last_in    = 1'b1;
         end
         default: begin
            carrier_in = 1'b1;
         end
      endcase
   end

   // job and step counter
   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      seg_in       = seg_ff;
      if (job_advance) begin
         if (job_last) begin
            job_valid_in = 1'b0;
         end else if (job_ff.sync) begin
            seg_in = SEG_TAIL;
         end else begin
            seg_in = seg_ff + 2'd1;
         end
      end
      if (job_take) begin
         job_valid_in = 1'b1;
         job_in       = job_new;
         seg_in       = SEG_LEAD;
      end
   end

   // result beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (job_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         seg_ff       <= SEG_LEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (job_advance) begin
         carrier_ff <= carrier_in;
         dur_ff     <= dur_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_carrier_high = carrier_ff;
   assign rsp_duration_ms  = dur_ff;
   assign rsp_last_segment = last_ff;

   // checks
   `MSF_ASSERT_NOW(a_take_only_when_free, job_take, status.take_ready,
      "new job taken while a second is still in progress")
   `MSF_ASSERT_NEXT(a_job_held_until_tail, job_advance && !job_last && !job_take,
      job_valid_ff, "job dropped before its final segment")
   `MSF_ASSERT_NEXT(a_stall_holds_step, job_valid_ff && rsp_valid_ff && !rsp_ready,
      $stable(seg_ff) && $stable(dur_ff), "segment step moved while result stalled")

endmodule

>>> hw/rtl/msf_time_code_modulator.sv
// top level of the msf time-code modulator
// depends on msf_tcm_pkg, msf_tcm_frame_store and msf_tcm_seg_sequencer
//
//   channel   direction  beat contents
//   req_      in         operation, time fields, summer_time, second
//   rsp_      out        carrier_high, duration_ms, last_segment
//
// a load beat updates the frames and gives no result
// a second beat gives 2 segments (second 0) or 4, one per cycle while the result
// is not stalled, the single result register stepping through them
// the next beat is taken in the cycle its predecessor's last segment is issued
// reset clears the frames to zero and empties the job and result registers
// a stalled result holds the segment step; loads still wait for the job slot
`timescale 1ns / 1ps

module msf_time_code_modulator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [6:0] req_year_of_century,
   input  logic [3:0] req_month,
   input  logic [4:0] req_day_of_month,
   input  logic [2:0] req_weekday,
   input  logic [4:0] req_hour,
   input  logic [5:0] req_minute,
   input  logic       req_summer_time,
   input  logic [5:0] req_second,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_carrier_high,
   output logic [8:0] rsp_duration_ms,
   output logic       rsp_last_segment
);
   import msf_tcm_pkg::*;

   seq_status_type status;
   job_type        job_new;
   logic           req_beat;
   logic           load_en;
   logic           job_take;

   // beat decode
   assign req_ready = status.take_ready;
   assign req_beat  = req_valid && req_ready;
   assign load_en   = req_beat && (req_operation == OP_LOAD);
   assign job_take  = req_beat && (req_operation == OP_MODULATE);

   msf_tcm_frame_store u_frames (
      .clock           (clock),
      .reset           (reset),
      .load_en         (load_en),
      .year_of_century (req_year_of_century),
      .month           (req_month),
      .day_of_month    (req_day_of_month),
      .weekday         (req_weekday),
      .hour            (req_hour),
      .minute          (req_minute),
      .summer_time     (req_summer_time),
      .second          (req_second),
      .job             (job_new)
   );

   msf_tcm_seg_sequencer u_seq (
      .clock            (clock),
      .reset            (reset),
      .job_take         (job_take),
      .job_new          (job_new),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_carrier_high (rsp_carrier_high),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

>>> tb/sv/tb.sv
// self-checking testbench of the msf time-code modulator
// drives load and second beats, predicts every carrier segment and checks each rsp beat
// depends on msf_tcm_pkg and msf_time_code_modulator
`timescale 1ns / 1ps

module tb;
   import msf_tcm_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 300;
   localparam int MAX_REPORTS  = 10;

   // seconds probed right after the largest legal load
   localparam int PROBE_COUNT = 9;
   localparam int PROBE_SECS [PROBE_COUNT] = '{0, 17, 24, 52, 53, 54, 57, 58, 59};

   // one request beat as queued for the driver
   typedef struct {
      logic       op;
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic       summer;
      logic [5:0] second;
   } time_beat_type;

   // one carrier segment as expected on the rsp channel
   typedef struct {
      logic       carrier_high;
      logic [8:0] duration_ms;
      logic       last_segment;
   } segment_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_operation;
   logic [6:0] req_year_of_century;
   logic [3:0] req_month;
   logic [4:0] req_day_of_month;
   logic [2:0] req_weekday;
   logic [4:0] req_hour;
   logic [5:0] req_minute;
   logic       req_summer_time;
   logic [5:0] req_second;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_carrier_high;
   logic [8:0] rsp_duration_ms;
   logic       rsp_last_segment;

   time_beat_type beat_queue[$];
   segment_type   seg_expect[$];
   logic [59:0]   frame_a;
   logic [59:0]   frame_b;
   logic          req_taken;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            long_hold_left;
   int            fail_count;
   int            cycle_count = 0;

   msf_time_code_modulator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_year_of_century(req_year_of_century),
      .req_month          (req_month),
      .req_day_of_month   (req_day_of_month),
      .req_weekday        (req_weekday),
      .req_hour           (req_hour),
      .req_minute         (req_minute),
      .req_summer_time    (req_summer_time),
      .req_second         (req_second),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_carrier_high   (rsp_carrier_high),
      .rsp_duration_ms    (rsp_duration_ms),
      .rsp_last_segment   (rsp_last_segment)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // two bcd digits, tens digit wraps modulo ten
   function automatic logic [63:0] two_digit_bcd(input int unsigned v);
      return 64'((((v / 10) % 10) << 4) | (v % 10));
   endfunction

   // parity bit that makes the ones over a[hi:lo] plus itself odd
   function automatic logic odd_fill(input logic [59:0] a, input int lo, input int hi);
      logic ones;
      ones = 1'b0;
      for (int i = lo; i <= hi; i++) ones ^= a[i];
      return ~ones;
   endfunction

   // rebuild both frames from a load beat
   function automatic void load_frames(input logic [6:0] year, input logic [3:0] month,
                                       input logic [4:0] day, input logic [2:0] weekday,
                                       input logic [4:0] hour, input logic [5:0] minute,
                                       input logic summer);
      logic [63:0] a;
      a = 64'(MARKER_BITS);
      a |= two_digit_bcd(year) << 35;
      a |= two_digit_bcd(month) << 30;
      a |= two_digit_bcd(day) << 24;
      a |= two_digit_bcd(weekday) << 21;
      a |= two_digit_bcd(hour) << 15;
      a |= two_digit_bcd(minute) << 8;
      frame_a = a[59:0];
      frame_b = '0;
      frame_b[5] = odd_fill(frame_a, 35, 42);
      frame_b[4] = odd_fill(frame_a, 24, 34);
      frame_b[3] = odd_fill(frame_a, 21, 23);
      frame_b[2] = odd_fill(frame_a, 8, 20);
      frame_b[SUMMER_POS] = summer;
   endfunction

   function automatic void push_segment(input logic c, input logic [8:0] d, input logic l);
      segment_type s;
      s.carrier_high = c;
      s.duration_ms  = d;
      s.last_segment = l;
      seg_expect.push_back(s);
   endfunction

   // carrier segments of one second, from the current frames
   function automatic void queue_second_segments(input logic [5:0] s);
      logic a_bit;
      logic b_bit;
      a_bit = 1'b0;
      b_bit = 1'b0;
      if (s == 6'd0) begin
         push_segment(1'b0, SYNC_MS, 1'b0);
         push_segment(1'b1, HOLD_MS, 1'b1);
      end else begin
         // seconds past the end of the minute read as zero bits
         if (s <= SEC_LAST) begin
            a_bit = frame_a[SEC_LAST - s];
            b_bit = frame_b[SEC_LAST - s];
         end
         push_segment(1'b0, BIT_MS, 1'b0);
         push_segment(~a_bit, BIT_MS, 1'b0);
         push_segment(~b_bit, BIT_MS, 1'b0);
         push_segment(1'b1, HOLD_MS, 1'b1);
      end
   endfunction

   // load beat; the second field carries noise
   function automatic void add_load(input int y, input int m, input int d, input int w,
                                    input int h, input int mi, input int st);
      time_beat_type b;
      b.op      = OP_LOAD;
      b.year    = 7'(y);
      b.month   = 4'(m);
      b.day     = 5'(d);
      b.weekday = 3'(w);
      b.hour    = 5'(h);
      b.minute  = 6'(mi);
      b.summer  = 1'(st);
      b.second  = 6'($urandom_range(63));
      beat_queue.push_back(b);
   endfunction

   // second beat; the time fields carry noise
   function automatic void add_second(input int s);
      time_beat_type b;
      b.op      = OP_MODULATE;
      b.year    = 7'($urandom_range(127));
      b.month   = 4'($urandom_range(15));
      b.day     = 5'($urandom_range(31));
      b.weekday = 3'($urandom_range(7));
      b.hour    = 5'($urandom_range(31));
      b.minute  = 6'($urandom_range(63));
      b.summer  = 1'($urandom_range(1));
      b.second  = 6'(s);
      beat_queue.push_back(b);
   endfunction

   // load with mostly legal fields, now and then the full field width
   function automatic void add_random_load();
      logic wild;
      wild = ($urandom_range(4) == 0);
      add_load(wild ? $urandom_range(127) : $urandom_range(99),
               wild ? $urandom_range(15)  : $urandom_range(1, 12),
               wild ? $urandom_range(31)  : $urandom_range(1, 31),
               wild ? $urandom_range(7)   : $urandom_range(6),
               wild ? $urandom_range(31)  : $urandom_range(23),
               wild ? $urandom_range(63)  : $urandom_range(59),
               $urandom_range(1));
   endfunction

   function automatic int random_second();
      return ($urandom_range(9) == 0) ? $urandom_range(60, 63) : $urandom_range(59);
   endfunction

   // mostly a load followed by a run of consecutive seconds, some lone beats as noise
   function automatic void add_random_beats(input int n);
      int added;
      int run;
      int s;
      added = 0;
      while (added < n) begin
         if ($urandom_range(5) == 0) begin
            if ($urandom_range(1) == 0) add_random_load();
            else add_second(random_second());
            added++;
         end else begin
            add_random_load();
            run = $urandom_range(2, 6);
            s   = $urandom_range(59);
            for (int i = 0; i < run; i++) add_second((s + i) % 60);
            added += run + 1;
         end
      end
   endfunction

   task automatic wait_accepted();
      while (beat_queue.size() != 0 || req_valid) @(posedge clock);
   endtask

   // req driver: next beat from the queue or an idle cycle
   always @(negedge clock) begin : req_driver
      time_beat_type nb;
      if (!reset && (!req_valid || req_taken)) begin
         if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nb = beat_queue.pop_front();
            req_valid           <= 1'b1;
            req_operation       <= nb.op;
            req_year_of_century <= nb.year;
            req_month           <= nb.month;
            req_day_of_month    <= nb.day;
            req_weekday         <= nb.weekday;
            req_hour            <= nb.hour;
            req_minute          <= nb.minute;
            req_summer_time     <= nb.summer;
            req_second          <= nb.second;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp ready: long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin : rsp_driver
      if (long_hold_left > 0) begin
         rsp_ready <= 1'b0;
         long_hold_left = long_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // predict on each accepted req beat, check each accepted rsp beat
   always @(posedge clock) begin : monitor
      segment_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            if (req_operation == OP_LOAD)
               load_frames(req_year_of_century, req_month, req_day_of_month, req_weekday,
                           req_hour, req_minute, req_summer_time);
            else
               queue_second_segments(req_second);
         end
         if (rsp_valid && rsp_ready) begin
            if (seg_expect.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected segment: carrier %0d duration %0d last %0d",
                           rsp_carrier_high, rsp_duration_ms, rsp_last_segment);
            end else begin
               want = seg_expect.pop_front();
               if (rsp_carrier_high !== want.carrier_high ||
                   rsp_duration_ms !== want.duration_ms ||
                   rsp_last_segment !== want.last_segment) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("segment mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.carrier_high, want.duration_ms, want.last_segment,
                              rsp_carrier_high, rsp_duration_ms, rsp_last_segment);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // reset, directed beats, idling phases, back-pressure, then the verdict
   initial begin : stimulus
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = OP_LOAD;
      req_year_of_century = '0;
      req_month           = '0;
      req_day_of_month    = '0;
      req_weekday         = '0;
      req_hour            = '0;
      req_minute          = '0;
      req_summer_time     = 1'b0;
      req_second          = '0;
      rsp_ready           = 1'b0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      long_hold_left      = 0;
      fail_count          = 0;
      frame_a             = '0;
      frame_b             = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // seconds before any load see the cleared frames
      add_second(0);
      add_second(17);
      add_second(63);
      // largest legal time with summer time set
      add_load(99, 12, 31, 6, 23, 59, 1);
      for (int i = 0; i < PROBE_COUNT; i++)
         add_second(PROBE_SECS[i]);
      // every field at its full width, tens digits wrap
      add_load(127, 15, 31, 7, 31, 63, 0);
      add_second(35);
      add_second(55);
      add_second(60);
      // smallest legal time
      add_load(0, 1, 1, 0, 0, 0, 0);
      add_second(45);
      add_second(56);
      add_second(61);
      add_second(62);
      // all-zero fields, only the summer flag
      add_load(0, 0, 0, 0, 0, 0, 1);
      add_second(58);
      wait_accepted();

      // idling phases
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         add_random_beats(25);
         wait_accepted();
      end

      // long rsp hold-off while the sender keeps offering second beats
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      long_hold_left = LONG_HOLD;
      add_random_load();
      for (int i = 0; i < 12; i++) add_second(random_second());
      wait_accepted();

      while (seg_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/msf_tcm_pkg.sv
hw/rtl/msf_tcm_frame_store.sv
hw/rtl/msf_tcm_seg_sequencer.sv
hw/rtl/msf_time_code_modulator.sv
tb/sv/tb.sv
